// File: design/sfd_pkg.sv
// Shared types and constants for the serial frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned CHECKSUM_W   = 16;
    localparam int unsigned CFG_ADDR_W   = 1;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] MAX_LEN_RESET      = 8'd128;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_MARKER = 1'b0,
        CFG_MAX_LEN      = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_ID     = 3'd1,
        PH_LEN    = 3'd2,
        PH_PAY    = 3'd3,
        PH_CK_HI  = 3'd4,
        PH_CK_LO  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY      = 2'd0,
        ST_BAD_START = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_DONE      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ROLE_START  = 3'd0,
        ROLE_ID     = 3'd1,
        ROLE_LEN    = 3'd2,
        ROLE_PAY    = 3'd3,
        ROLE_CK_HI  = 3'd4,
        ROLE_CK_LO  = 3'd5
    } role_t;

    typedef struct packed {
        logic [CHECKSUM_W-1:0] checksum_value;
        logic [BYTE_W-1:0]     frame_length;
        logic [BYTE_W-1:0]     msg_id;
        logic [BYTE_W-1:0]     payload_index;
        logic [BYTE_W-1:0]     payload_byte;
        role_t                 byte_role;
        status_t               status;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] max_payload_len;
    } cfg_t;

endpackage

// File: design/sfd_parser.sv
// Frame parsing state machine: phase, counters and the result of one byte.
`timescale 1ns / 1ps

module sfd_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [sfd_pkg::BYTE_W-1:0]  rx_byte,
    input  sfd_pkg::cfg_t               cfg,
    output sfd_pkg::result_t            result
);

    sfd_pkg::phase_t             phase_reg, phase_next;
    logic [sfd_pkg::BYTE_W-1:0]  pos_reg, pos_next;
    logic [sfd_pkg::BYTE_W-1:0]  id_reg, id_next;
    logic [sfd_pkg::BYTE_W-1:0]  len_reg, len_next;
    logic [sfd_pkg::BYTE_W-1:0]  ck_hi_reg, ck_hi_next;
    logic [sfd_pkg::BYTE_W-1:0]  pos_inc;

    assign pos_inc = pos_reg + 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sfd_pkg::PH_START;
            pos_reg   <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            ck_hi_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            ck_hi_reg <= ck_hi_next;
        end
    end

    // Next-state logic.
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        ck_hi_next = ck_hi_reg;
        case (phase_reg)
            sfd_pkg::PH_ID: begin
                id_next    = rx_byte;
                phase_next = sfd_pkg::PH_LEN;
            end
            sfd_pkg::PH_LEN: begin
                len_next = rx_byte;
                pos_next = '0;
                if (rx_byte > cfg.max_payload_len) begin
                    phase_next = sfd_pkg::PH_START;
                end else if (rx_byte == '0) begin
                    phase_next = sfd_pkg::PH_CK_HI;
                end else begin
                    phase_next = sfd_pkg::PH_PAY;
                end
            end
            sfd_pkg::PH_PAY: begin
                pos_next = pos_inc;
                if (pos_inc >= len_reg) begin
                    phase_next = sfd_pkg::PH_CK_HI;
                end
            end
            sfd_pkg::PH_CK_HI: begin
                ck_hi_next = rx_byte;
                phase_next = sfd_pkg::PH_CK_LO;
            end
            sfd_pkg::PH_CK_LO: begin
                phase_next = sfd_pkg::PH_START;
            end
            default: begin
                if (rx_byte == cfg.start_marker) begin
                    phase_next = sfd_pkg::PH_ID;
                end else begin
                    phase_next = sfd_pkg::PH_START;
                end
            end
        endcase
    end

    // Output logic; the id and length fields report the values after this byte.
    always_comb begin
        result                = '0;
        result.status         = sfd_pkg::ST_BUSY;
        result.byte_role      = sfd_pkg::ROLE_START;
        result.msg_id         = id_next;
        result.frame_length   = len_next;
        case (phase_reg)
            sfd_pkg::PH_ID: begin
                result.byte_role = sfd_pkg::ROLE_ID;
            end
            sfd_pkg::PH_LEN: begin
                result.byte_role = sfd_pkg::ROLE_LEN;
                if (rx_byte > cfg.max_payload_len) begin
                    result.status = sfd_pkg::ST_TOO_LONG;
                end
            end
            sfd_pkg::PH_PAY: begin
                result.byte_role     = sfd_pkg::ROLE_PAY;
                result.payload_byte  = rx_byte;
                result.payload_index = pos_reg;
            end
            sfd_pkg::PH_CK_HI: begin
                result.byte_role = sfd_pkg::ROLE_CK_HI;
            end
            sfd_pkg::PH_CK_LO: begin
                result.byte_role      = sfd_pkg::ROLE_CK_LO;
                result.status         = sfd_pkg::ST_DONE;
                result.checksum_value = {ck_hi_reg, rx_byte};
            end
            default: begin
                if (rx_byte != cfg.start_marker) begin
                    result.status = sfd_pkg::ST_BAD_START;
                end
            end
        endcase
    end

endmodule

// File: design/serial_frame_deframer_core.sv
// Top level of the serial frame deframer: input register, parser, result register.
`timescale 1ns / 1ps

// Usage:
// Received bytes enter as beats on the s_ channel, one byte in s_tdata. Every
// byte produces exactly one result beat on the m_ channel, in order. The
// result beat carries the status and the byte role in m_tuser and the payload
// byte, payload index, message id, frame length and checksum in m_tdata.
// A byte accepted into the input register is parsed from there by the
// combinational parser, and its result is captured in the result register,
// which drives m_tvalid. One byte per cycle is sustained while m_tready
// stays high; the only loop is the parser state update.
// When the receiver holds m_tready low, the result register holds its beat
// and the input register can still take one more byte; after that s_tready
// falls until the result beat is taken.
// The configuration port writes the start marker and the payload length
// limit; writes are meant to happen while no beats are in flight.
// Reset (aresetn low, synchronous) empties both registers, returns the parser
// to waiting for a start byte and restores the register defaults.

module serial_frame_deframer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sfd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [sfd_pkg::BYTE_W-1:0]          cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [23:16] msg_id,
    // [31:24] frame_length, [47:32] checksum_value
    output logic [47:0]                         m_tdata,
    output logic [4:0]                          m_tuser    // [1:0] status, [4:2] byte_role
);

    sfd_pkg::cfg_t               cfg_reg;
    logic                        in_valid_reg;
    logic [sfd_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        out_valid_reg;
    sfd_pkg::result_t            out_reg;
    sfd_pkg::result_t            result;
    logic                        out_ready;
    logic                        advance;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker    <= sfd_pkg::START_MARKER_RESET;
            cfg_reg.max_payload_len <= sfd_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            case (sfd_pkg::cfg_index_t'(cfg_addr))
                sfd_pkg::CFG_START_MARKER: cfg_reg.start_marker    <= cfg_wr_data;
                sfd_pkg::CFG_MAX_LEN:      cfg_reg.max_payload_len <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    sfd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.byte_role, out_reg.status};
    assign m_tdata  = {out_reg.checksum_value, out_reg.frame_length, out_reg.msg_id,
                       out_reg.payload_index, out_reg.payload_byte};

    // A completed frame is always reported on its low checksum byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.status == sfd_pkg::ST_DONE
        |-> out_reg.byte_role == sfd_pkg::ROLE_CK_LO)
        else $error("frame complete reported on a byte other than checksum low");

    // A bad start byte can only be seen while waiting for a start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.status == sfd_pkg::ST_BAD_START
        |-> out_reg.byte_role == sfd_pkg::ROLE_START)
        else $error("bad start status on a byte that is not a start candidate");

    // Only payload beats carry payload data or an index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.byte_role != sfd_pkg::ROLE_PAY
        |-> out_reg.payload_byte == '0 && out_reg.payload_index == '0)
        else $error("payload fields set on a non-payload beat");

    // The checksum is zero unless the frame completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.status != sfd_pkg::ST_DONE
        |-> out_reg.checksum_value == '0)
        else $error("checksum reported before frame completion");

    // Nothing comes out in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

endmodule
